// ===== src/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, configuration bundle and fixed-point helpers of the quintic
// trajectory evaluator.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int S_BITS     = 30;
  localparam int RECIP_BITS = 47;
  localparam int COEF_W     = 48;
  localparam int WIDE_W     = 56;

  // register indexes of the configuration port
  localparam logic [1:0] REG_INIT_POS = 2'd0;
  localparam logic [1:0] REG_TARGET   = 2'd1;
  localparam logic [1:0] REG_INIT_VEL = 2'd2;
  localparam logic [1:0] REG_SPAN     = 2'd3;

  // datapath values; user keeps them stable with beats in flight, unenforced
  typedef struct packed {
    logic signed [31:0] p0;
    logic signed [31:0] pf;
    logic        [30:0] span;
    logic        [47:0] recip;
    logic signed [47:0] vel;
    logic signed [47:0] c3;
    logic signed [47:0] c4;
    logic signed [47:0] c5;
  } qte_cfg_t;

  // partial products of a coefficient times a Q0.30 power of s
  typedef struct packed {
    logic signed [57:0] hi;
    logic        [56:0] lo;
  } qte_tpp_t;

  // partial products of a 56-bit sum times the 48-bit span reciprocal
  typedef struct packed {
    logic signed [52:0] hh;
    logic signed [52:0] hl;
    logic        [51:0] lh;
    logic        [51:0] ll;
  } qte_wpp_t;

  function automatic qte_tpp_t term_pp(input logic signed [53:0] a, input logic [29:0] s);
    qte_tpp_t p;
    p.hi = $signed(a[53:27]) * $signed({1'b0, s});
    p.lo = a[26:0] * s;
    return p;
  endfunction

  // floor(a * s / 2^30), exact
  function automatic logic signed [54:0] term_val(input qte_tpp_t p);
    logic signed [84:0] full;
    full = (85'(p.hi) <<< 27) + $signed(85'(p.lo));
    return full[84:30];
  endfunction

  function automatic qte_wpp_t wide_pp(input logic signed [55:0] x, input logic [47:0] r);
    qte_wpp_t p;
    p.hh = $signed(x[55:28]) * $signed({1'b0, r[47:24]});
    p.hl = $signed(x[55:28]) * $signed({1'b0, r[23:0]});
    p.lh = x[27:0] * r[47:24];
    p.ll = x[27:0] * r[23:0];
    return p;
  endfunction

  function automatic logic signed [104:0] wide_sum(input qte_wpp_t p);
    return (105'(p.hh) <<< 52) + (105'(p.hl) <<< 28)
         + $signed(105'(p.lh) << 24) + $signed(105'(p.ll));
  endfunction

  // floor(product / 2^(RECIP_BITS - FRAC_BITS))
  function automatic logic signed [73:0] wide_shift(input logic signed [104:0] full);
    return full[104:31];
  endfunction

  function automatic logic signed [55:0] sat_w56(input logic signed [73:0] x);
    if (x[73:55] != {19{x[73]}}) begin
      return x[73] ? {1'b1, {55{1'b0}}} : {1'b0, {55{1'b1}}};
    end
    return x[55:0];
  endfunction

  function automatic logic signed [31:0] sat_w32(input logic signed [73:0] x);
    if (x[73:31] != {43{x[73]}}) begin
      return x[73] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end
    return x[31:0];
  endfunction

endpackage

// ===== src/qte_datapath.sv =====
// ----------------------------------------------------------------------------
// qte_datapath
// Sixteen-stage evaluation pipeline: normalized time, its powers, the
// polynomial terms, the sums and the two divisions by the span.
// ----------------------------------------------------------------------------
module qte_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_fire,
  input  logic signed [31:0] sample_time,
  input  qte_pkg::qte_cfg_t  cfg,
  output logic               out_valid,
  output logic signed [31:0] position,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration
);

  localparam int NSTG = 16;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-2:0] clamp_r;
  logic [NSTG-2:0] at_end_r;

  // coefficient multiples, static between configurations
  logic signed [53:0] v54, c3x1, c4x1, c5x1, c3x3, c4x4, c5x5, c3x6, c4x12, c5x20;
  assign v54   = 54'(cfg.vel);
  assign c3x1  = 54'(cfg.c3);
  assign c4x1  = 54'(cfg.c4);
  assign c5x1  = 54'(cfg.c5);
  assign c3x3  = c3x1 * 54'sd3;
  assign c4x4  = c4x1 * 54'sd4;
  assign c5x5  = c5x1 * 54'sd5;
  assign c3x6  = c3x1 * 54'sd6;
  assign c4x12 = c4x1 * 54'sd12;
  assign c5x20 = c5x1 * 54'sd20;

  logic               le0, past_end;
  assign le0      = sample_time[31] || (sample_time == 32'sd0);
  assign past_end = !le0 && (sample_time[30:0] >= cfg.span);

  logic [54:0] pa1_r, pb1_r;
  logic [78:0] tr_sum;
  assign tr_sum = (79'(pa1_r) << 24) + 79'(pb1_r);

  logic [29:0] s1_2_r;
  logic [29:0] s1_3_r, s2_3_r;
  logic [29:0] s1_4_r, s2_4_r, s3_4_r;
  logic [29:0] s1_5_r, s2_5_r, s3_5_r, s4_5_r;
  logic [29:0] s1_6_r, s2_6_r, s3_6_r, s4_6_r, s5_6_r;

  logic [59:0] m23, m34, m45, m56;
  assign m23 = s1_2_r * s1_2_r;
  assign m34 = s2_3_r * s1_3_r;
  assign m45 = s3_4_r * s1_4_r;
  assign m56 = s4_5_r * s1_5_r;

  qte_pkg::qte_tpp_t pp_p1_r, pp_p3_r, pp_p4_r, pp_p5_r;
  qte_pkg::qte_tpp_t pp_v2_r, pp_v3_r, pp_v4_r;
  qte_pkg::qte_tpp_t pp_a1_r, pp_a2_r, pp_a3_r;

  logic signed [54:0] tm_p1_r, tm_p3_r, tm_p4_r, tm_p5_r;
  logic signed [54:0] tm_v2_r, tm_v3_r, tm_v4_r;
  logic signed [54:0] tm_a1_r, tm_a2_r, tm_a3_r;

  logic signed [59:0] pos_sum_r;
  logic signed [57:0] vs_sum_r, as_sum_r;

  logic signed [31:0] pos10_r, pos11_r, pos12_r, pos13_r, pos14_r, pos15_r;
  logic signed [55:0] vs10_r, as10_r;
  qte_pkg::qte_wpp_t  wv11_r, wa11_r, wb14_r;
  logic signed [104:0] fv12_r, fa12_r, fb15_r;
  logic signed [31:0] vel13_r, vel14_r, vel15_r;
  logic signed [55:0] a13_r;

  logic signed [31:0] pos_o_r, vel_o_r, acc_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_r  <= {clamp_r[NSTG-3:0], le0 || past_end};
      at_end_r <= {at_end_r[NSTG-3:0], past_end};

      // normalized time s = t * R / 2^17
      pa1_r  <= sample_time[30:0] * cfg.recip[47:24];
      pb1_r  <= sample_time[30:0] * cfg.recip[23:0];
      s1_2_r <= tr_sum[46:17];

      // powers of s, one multiply per stage
      s1_3_r <= s1_2_r;
      s2_3_r <= m23[59:30];
      s1_4_r <= s1_3_r;
      s2_4_r <= s2_3_r;
      s3_4_r <= m34[59:30];
      s1_5_r <= s1_4_r;
      s2_5_r <= s2_4_r;
      s3_5_r <= s3_4_r;
      s4_5_r <= m45[59:30];
      s1_6_r <= s1_5_r;
      s2_6_r <= s2_5_r;
      s3_6_r <= s3_5_r;
      s4_6_r <= s4_5_r;
      s5_6_r <= m56[59:30];

      pp_p1_r <= qte_pkg::term_pp(v54,   s1_6_r);
      pp_p3_r <= qte_pkg::term_pp(c3x1,  s3_6_r);
      pp_p4_r <= qte_pkg::term_pp(c4x1,  s4_6_r);
      pp_p5_r <= qte_pkg::term_pp(c5x1,  s5_6_r);
      pp_v2_r <= qte_pkg::term_pp(c3x3,  s2_6_r);
      pp_v3_r <= qte_pkg::term_pp(c4x4,  s3_6_r);
      pp_v4_r <= qte_pkg::term_pp(c5x5,  s4_6_r);
      pp_a1_r <= qte_pkg::term_pp(c3x6,  s1_6_r);
      pp_a2_r <= qte_pkg::term_pp(c4x12, s2_6_r);
      pp_a3_r <= qte_pkg::term_pp(c5x20, s3_6_r);

      tm_p1_r <= qte_pkg::term_val(pp_p1_r);
      tm_p3_r <= qte_pkg::term_val(pp_p3_r);
      tm_p4_r <= qte_pkg::term_val(pp_p4_r);
      tm_p5_r <= qte_pkg::term_val(pp_p5_r);
      tm_v2_r <= qte_pkg::term_val(pp_v2_r);
      tm_v3_r <= qte_pkg::term_val(pp_v3_r);
      tm_v4_r <= qte_pkg::term_val(pp_v4_r);
      tm_a1_r <= qte_pkg::term_val(pp_a1_r);
      tm_a2_r <= qte_pkg::term_val(pp_a2_r);
      tm_a3_r <= qte_pkg::term_val(pp_a3_r);

      pos_sum_r <= 60'(cfg.p0) + 60'(tm_p1_r) + 60'(tm_p3_r) + 60'(tm_p4_r)
                 + 60'(tm_p5_r);
      vs_sum_r  <= 58'(cfg.vel) + 58'(tm_v2_r) + 58'(tm_v3_r) + 58'(tm_v4_r);
      as_sum_r  <= 58'(tm_a1_r) + 58'(tm_a2_r) + 58'(tm_a3_r);

      pos10_r <= qte_pkg::sat_w32(74'(pos_sum_r));
      vs10_r  <= qte_pkg::sat_w56(74'(vs_sum_r));
      as10_r  <= qte_pkg::sat_w56(74'(as_sum_r));

      // first division by the span
      pos11_r <= pos10_r;
      wv11_r  <= qte_pkg::wide_pp(vs10_r, cfg.recip);
      wa11_r  <= qte_pkg::wide_pp(as10_r, cfg.recip);
      pos12_r <= pos11_r;
      fv12_r  <= qte_pkg::wide_sum(wv11_r);
      fa12_r  <= qte_pkg::wide_sum(wa11_r);
      pos13_r <= pos12_r;
      vel13_r <= qte_pkg::sat_w32(qte_pkg::wide_shift(fv12_r));
      a13_r   <= qte_pkg::sat_w56(qte_pkg::wide_shift(fa12_r));

      // second division for acceleration
      pos14_r <= pos13_r;
      vel14_r <= vel13_r;
      wb14_r  <= qte_pkg::wide_pp(a13_r, cfg.recip);
      pos15_r <= pos14_r;
      vel15_r <= vel14_r;
      fb15_r  <= qte_pkg::wide_sum(wb14_r);

      if (clamp_r[NSTG-2]) begin
        pos_o_r <= at_end_r[NSTG-2] ? cfg.pf : cfg.p0;
        vel_o_r <= '0;
        acc_o_r <= '0;
      end else begin
        pos_o_r <= pos15_r;
        vel_o_r <= vel15_r;
        acc_o_r <= qte_pkg::sat_w32(qte_pkg::wide_shift(fb15_r));
      end
    end
  end

  assign out_valid    = vld_r[NSTG-1];
  assign position     = pos_o_r;
  assign velocity     = vel_o_r;
  assign acceleration = acc_o_r;

endmodule

// ===== src/quintic_trajectory_evaluator.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator
// One axis of a quintic trajectory: register port, closed-form coefficient
// derivation with a bit-serial span reciprocal, and the evaluation pipeline.
//
//   channel | ports                                   | beat
//   --------+-----------------------------------------+---------------------
//   in      | in_valid in_stall in_sample_time        | one query time
//   out     | out_valid out_stall out_position ...    | pos, vel, acc
//   cfg     | psel penable pwrite paddr pwdata prdata | one register write
//
// One beat per cycle, while neither a derivation nor out_stall holds the pipeline.
// Every register write starts a derivation (one quotient bit per cycle
// of the reciprocal divider); in_stall is high during it.
// After reset the reciprocal and coefficients are zero until the first write.
// out_stall freezes the whole pipeline while out_valid is high, in_stall follows it.
// ----------------------------------------------------------------------------
module quintic_trajectory_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity,
  output logic signed [31:0] out_acceleration,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [5:0] STEP_VPROD = 6'd0;
  localparam logic [5:0] STEP_SHAPE = 6'd1;
  localparam logic [5:0] STEP_COEF  = 6'd2;
  localparam logic [5:0] DIV_LAST   = 6'(qte_pkg::RECIP_BITS);

  logic signed [31:0] p0_r, pf_r, v0_r;
  logic        [30:0] span_r;
  logic        [47:0] recip_r;
  logic signed [47:0] vel_r, c3_r, c4_r, c5_r, d_r;
  logic signed [63:0] vprod_r;
  logic               busy_r;
  logic        [5:0]  cnt_r;
  logic        [30:0] rem_r;
  logic        [46:0] quo_r;

  logic wr_fire;
  assign wr_fire = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      qte_pkg::REG_INIT_POS: prdata = p0_r;
      qte_pkg::REG_TARGET:   prdata = pf_r;
      qte_pkg::REG_INIT_VEL: prdata = v0_r;
      qte_pkg::REG_SPAN:     prdata = {1'b0, span_r};
      default:               prdata = '0;
    endcase
  end

  // restoring divider step for 2^47 / span
  logic [31:0] trial, rem_nxt;
  logic        qbit;
  assign trial   = {rem_r, (cnt_r == STEP_VPROD)};
  assign qbit    = trial >= {1'b0, span_r};
  assign rem_nxt = qbit ? trial - {1'b0, span_r} : trial;

  function automatic logic signed [47:0] sat_w48(input logic signed [53:0] x);
    if (x[53:47] != {7{x[53]}}) begin
      return x[53] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end
    return x[47:0];
  endfunction

  logic signed [53:0] d54, v54;
  assign d54 = 54'(d_r);
  assign v54 = 54'(vel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r    <= '0;
      pf_r    <= '0;
      v0_r    <= '0;
      span_r  <= 31'(1 << qte_pkg::FRAC_BITS);
      recip_r <= '0;
      vel_r   <= '0;
      c3_r    <= '0;
      c4_r    <= '0;
      c5_r    <= '0;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (wr_fire) begin
      unique case (paddr[3:2])
        qte_pkg::REG_INIT_POS: p0_r   <= pwdata;
        qte_pkg::REG_TARGET:   pf_r   <= pwdata;
        qte_pkg::REG_INIT_VEL: v0_r   <= pwdata;
        qte_pkg::REG_SPAN:     span_r <= pwdata[30:0];
        default:               ;
      endcase
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == STEP_SHAPE) begin
        vel_r <= $signed(vprod_r[63:16]);
      end
      if (cnt_r == STEP_COEF) begin
        c3_r <= sat_w48(54'sd10 * d54 + 54'sd4 * v54);
        c4_r <= sat_w48(54'sd0 - 54'sd15 * d54 - 54'sd7 * v54);
        c5_r <= sat_w48(54'sd6 * d54 + 54'sd3 * v54);
      end
      if (cnt_r == DIV_LAST) begin
        recip_r <= (span_r == '0) ? '0 : {quo_r, qbit};
        busy_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt[30:0];
      quo_r <= {quo_r[45:0], qbit};
      if (cnt_r == STEP_VPROD) begin
        vprod_r <= v0_r * $signed({1'b0, span_r});
      end
      if (cnt_r == STEP_SHAPE) begin
        d_r <= 48'(pf_r) - 48'(p0_r) - $signed(vprod_r[63:16]);
      end
    end
  end

  qte_pkg::qte_cfg_t cfg;
  always_comb begin
    cfg.p0    = p0_r;
    cfg.pf    = pf_r;
    cfg.span  = span_r;
    cfg.recip = recip_r;
    cfg.vel   = vel_r;
    cfg.c3    = c3_r;
    cfg.c4    = c4_r;
    cfg.c5    = c5_r;
  end

  logic en, in_fire;
  assign en       = !(out_valid && out_stall);
  assign in_stall = busy_r || !en;
  assign in_fire  = in_valid && !in_stall;

  qte_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_fire      (in_fire),
    .sample_time  (in_sample_time),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .position     (out_position),
    .velocity     (out_velocity),
    .acceleration (out_acceleration)
  );

endmodule

// ===== bench/quintic_trajectory_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator_tb
// Drives query times into the evaluator under several register settings and
// checks every position, velocity and acceleration beat against an in-bench
// fixed-point model of the quintic path, with random idling and backpressure.
// ----------------------------------------------------------------------------
module quintic_trajectory_evaluator_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } motion_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_sample_time;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_position;
  logic signed [31:0] out_velocity;
  logic signed [31:0] out_acceleration;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  quintic_trajectory_evaluator dut (.*);

  // mirrored registers and derived state
  longint p0_q, pf_q, v0_q, span_q;
  longint recip_q, c3_q, c4_q, c5_q;

  motion_t expected_motion[$];
  int  tx_idle_pct, rx_idle_pct;
  int  hold_cycles;
  int  errors, beats_sent, beats_checked, cfg_writes;
  int  cycle_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp(longint x, int w);
    longint lim;
    lim = longint'(1) <<< (w - 1);
    if (x > lim - 1) return lim - 1;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // floor(a*b / 2^sh) clamped to 56 bits
  function automatic longint mul_floor(longint a, longint b, int sh);
    logic signed [127:0] p;
    logic signed [127:0] lim;
    p = 128'($signed(a)) * 128'($signed(b));
    p = p >>> sh;
    lim = 128'sd1 <<< (qte_pkg::WIDE_W - 1);
    if (p > lim - 1) p = lim - 1;
    if (p < -lim) p = -lim;
    return longint'(p);
  endfunction

  function automatic longint span_velocity();
    return clamp(mul_floor(v0_q, span_q, qte_pkg::FRAC_BITS), qte_pkg::COEF_W);
  endfunction

  function automatic void derive_shape();
    longint v, d;
    v = span_velocity();
    d = clamp(pf_q - p0_q - v, qte_pkg::COEF_W);
    recip_q = (span_q > 0)
            ? longint'((64'd1 << qte_pkg::RECIP_BITS) / 64'(span_q)) : 0;
    c3_q = clamp(10 * d + 4 * v, qte_pkg::COEF_W);
    c4_q = clamp(-15 * d - 7 * v, qte_pkg::COEF_W);
    c5_q = clamp(6 * d + 3 * v, qte_pkg::COEF_W);
  endfunction

  function automatic motion_t predict_motion(logic signed [31:0] t_in);
    motion_t m;
    longint t, v, pos, vs, as, vel, acc;
    longint s1, s2, s3, s4, s5;
    int dsh;
    t = t_in;
    dsh = qte_pkg::RECIP_BITS - qte_pkg::FRAC_BITS;
    vel = 0;
    acc = 0;
    if (t <= 0) begin
      pos = p0_q;
    end else if (t >= span_q) begin
      pos = pf_q;
    end else begin
      v = span_velocity();
      s1 = (t * recip_q) >>> (qte_pkg::RECIP_BITS - qte_pkg::S_BITS);
      s2 = (s1 * s1) >>> qte_pkg::S_BITS;
      s3 = (s2 * s1) >>> qte_pkg::S_BITS;
      s4 = (s3 * s1) >>> qte_pkg::S_BITS;
      s5 = (s4 * s1) >>> qte_pkg::S_BITS;
      pos = p0_q + mul_floor(v, s1, qte_pkg::S_BITS)
          + mul_floor(c3_q, s3, qte_pkg::S_BITS)
          + mul_floor(c4_q, s4, qte_pkg::S_BITS)
          + mul_floor(c5_q, s5, qte_pkg::S_BITS);
      vs = v + mul_floor(3 * c3_q, s2, qte_pkg::S_BITS)
         + mul_floor(4 * c4_q, s3, qte_pkg::S_BITS)
         + mul_floor(5 * c5_q, s4, qte_pkg::S_BITS);
      vel = mul_floor(clamp(vs, qte_pkg::WIDE_W), recip_q, dsh);
      as = mul_floor(6 * c3_q, s1, qte_pkg::S_BITS)
         + mul_floor(12 * c4_q, s2, qte_pkg::S_BITS)
         + mul_floor(20 * c5_q, s3, qte_pkg::S_BITS);
      acc = mul_floor(mul_floor(clamp(as, qte_pkg::WIDE_W), recip_q, dsh), recip_q, dsh);
    end
    m.pos = 32'(clamp(pos, qte_pkg::DATA_W));
    m.vel = 32'(clamp(vel, qte_pkg::DATA_W));
    m.acc = 32'(clamp(acc, qte_pkg::DATA_W));
    return m;
  endfunction

  task automatic send_time(logic signed [31:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_time <= t;
    do @(posedge clk); while (in_stall);
    expected_motion.push_back(predict_motion(t));
    beats_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    wait_drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 4'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      qte_pkg::REG_INIT_POS: p0_q   = longint'($signed(value));
      qte_pkg::REG_TARGET:   pf_q   = longint'($signed(value));
      qte_pkg::REG_INIT_VEL: v0_q   = longint'($signed(value));
      qte_pkg::REG_SPAN:     span_q = longint'(value[30:0]);
      default: ;
    endcase
    derive_shape();
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_path(logic [31:0] p0, logic [31:0] pf, logic [31:0] v0,
                          logic [31:0] span);
    write_reg(qte_pkg::REG_INIT_POS, p0);
    write_reg(qte_pkg::REG_TARGET, pf);
    write_reg(qte_pkg::REG_INIT_VEL, v0);
    write_reg(qte_pkg::REG_SPAN, span);
  endtask

  // boundary and interior times for the current span
  task automatic send_landmarks();
    send_time(32'sd0);
    send_time(-32'sd1);
    send_time(32'sh8000_0000);
    send_time(32'sh7fff_ffff);
    send_time(32'sd1);
    send_time(32'(span_q - 1));
    send_time(32'(span_q));
    send_time(32'(span_q / 4));
    send_time(32'(span_q / 2));
    send_time(32'(3 * (span_q / 4)));
    end_burst();
  endtask

  function automatic logic [31:0] random_time();
    if ($urandom_range(99) < 75) return 32'($urandom_range(32'(span_q)));
    return $urandom;
  endfunction

  // reciprocal and coefficients are still zero before the first write
  task automatic test_reset_state();
    send_time(32'sd0);
    send_time(32'sd32768);
    send_time(32'sd65536);
    send_time(-32'sd5);
    end_burst();
  endtask

  task automatic test_directed_motion();
    set_path(32'h0000_0000, 32'h000a_0000, 32'h0001_0000, 32'h0002_0000);
    send_landmarks();
    set_path(32'h0005_0000, 32'hfffb_0000, 32'hfffe_0000, 32'h0000_8000);
    send_landmarks();
  endtask

  task automatic test_saturation();
    set_path(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_landmarks();
    set_path(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_landmarks();
    write_reg(qte_pkg::REG_SPAN, 32'h0000_0400);
    send_landmarks();
  endtask

  // long receiver hold-off fills the pipeline, then a full drain pause
  task automatic test_backpressure();
    set_path(32'h0001_0000, 32'h0010_0000, 32'h0000_4000, 32'h0003_0000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles = 300;
    repeat (60) send_time(random_time());
    end_burst();
    wait_drain();
    repeat (20) send_time(random_time());
    end_burst();
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int n_items);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 30 == 0) begin
        end_burst();
        set_path($urandom, $urandom, ($urandom_range(3) == 0) ? $urandom
                 : 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000),
                 ($urandom_range(9) == 0) ? {1'b0, 31'($urandom)}
                 : $urandom_range(32'h0008_0000, 1));
      end
      send_time(random_time());
    end
    end_burst();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    motion_t exp_m;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_motion.size() == 0) begin
        $display("%0t: unexpected result beat pos=%h vel=%h acc=%h", $time,
                 out_position, out_velocity, out_acceleration);
        errors++;
      end else begin
        exp_m = expected_motion.pop_front();
        beats_checked++;
        if (out_position !== exp_m.pos) begin
          $display("%0t: position expected %h actual %h", $time, exp_m.pos, out_position);
          errors++;
        end
        if (out_velocity !== exp_m.vel) begin
          $display("%0t: velocity expected %h actual %h", $time, exp_m.vel, out_velocity);
          errors++;
        end
        if (out_acceleration !== exp_m.acc) begin
          $display("%0t: acceleration expected %h actual %h", $time, exp_m.acc,
                   out_acceleration);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_time = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    p0_q = 0;
    pf_q = 0;
    v0_q = 0;
    span_q = 65536;
    recip_q = 0;
    c3_q = 0;
    c4_q = 0;
    c5_q = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles = 0;
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    cfg_writes = 0;
    cycle_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_motion();
    test_saturation();
    test_backpressure();
    test_random(19, 79, 110);
    test_random(79, 19, 110);
    test_random(0, 0, 110);

    wait_drain();
    rx_idle_pct = 0;
    repeat (40) @(posedge clk);
    if (expected_motion.size() != 0) begin
      $display("%0d expected beats never arrived", expected_motion.size());
      errors++;
    end
    $display("covered %0d query beats (%0d checked) over %0d register writes,",
             beats_sent, beats_checked, cfg_writes);
    $display("including span extremes, saturating paths and a long output hold-off");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== quintic_trajectory_evaluator.f =====
src/qte_pkg.sv
src/qte_datapath.sv
src/quintic_trajectory_evaluator.sv
bench/quintic_trajectory_evaluator_tb.sv
